// ===== rtl/sor_sparse_sweep_assert.svh =====
// assertion macros for the sparse sor sweep block
`ifndef SOR_SPARSE_SWEEP_ASSERT_SVH
`define SOR_SPARSE_SWEEP_ASSERT_SVH

`ifndef SYNTH
`define SOR_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define SOR_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SOR_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define SOR_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

// ===== rtl/sor_pkg.sv =====
// shared types and constants of the sparse sor sweep block
package sor_pkg;
  localparam int DEF_ROWS      = 256;
  localparam int DEF_NONZEROS  = 4096;
  localparam int DEF_FRAC_BITS = 16;
  localparam int OMEGA_FRAC    = 16;
  localparam int QW            = 48;
  localparam logic [17:0] RELAX_RESET = 18'd65536;
  localparam logic [8:0]  ROWS_USE_RESET = 9'd256;

  typedef enum logic [1:0] {
    FUNC_LOAD_NZ  = 2'd0,
    FUNC_LOAD_ROW = 2'd1,
    FUNC_SWEEP    = 2'd2,
    FUNC_READ     = 2'd3
  } func_t;

  typedef enum logic {
    REG_RELAX = 1'b0,
    REG_ROWS  = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic info_we;
    logic x_we;
  } row_wr_t;
endpackage

// ===== rtl/sor_sparse_sweep.sv =====
// top level of the sparse sor sweep engine
//
// usage: a request is taken when start is high and busy is low. func selects
// load nonzero, load row, run sweep or read solution; the other in_ ports
// carry that request's payload. every request yields exactly one result,
// shown for one cycle with out_valid high; the receiver cannot stall it.
// request handling: load nonzero, load row and read requests finish
// with the result in the cycle after acceptance and may be issued every
// cycle (busy stays low). a sweep holds busy high and walks the rows in
// use from the row and nonzero memories: per row a row fetch (row check,
// row read) and a close (range end check, diagonal test), per diagonal or
// out of range nonzero a slot check and fetch, per off-diagonal nonzero a
// slot fetch, solution fetch, multiply and accumulate, then for a row with
// a nonzero diagonal the bit-serial divider (stopping early when the
// quotient saturates) and the update (multiply, write). after the last row,
// and also with zero rows in use, a final row check raises the registered result.
// reset clears the fsm, the zero diagonal flag and the configuration
// registers (omega 1.0, all rows); the memories hold whatever was loaded.
// configuration uses the apb port and may be written only while idle
module sor_sparse_sweep #(
  parameter int ROWS      = sor_pkg::DEF_ROWS,
  parameter int NONZEROS  = sor_pkg::DEF_NONZEROS,
  parameter int FRAC_BITS = sor_pkg::DEF_FRAC_BITS
) (
  input  logic               clk,
  input  logic               rst_n,
  // request channel
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_func,
  input  logic [7:0]         in_row,
  input  logic [11:0]        in_slot,
  input  logic [7:0]         in_column,
  input  logic signed [31:0] in_coef,
  input  logic [12:0]        in_row_first,
  input  logic [12:0]        in_row_stop,
  input  logic signed [31:0] in_rhs,
  input  logic signed [31:0] in_guess,
  // result channel
  output logic               out_valid,
  output logic signed [31:0] out_value,
  output logic               out_sweep_done,
  output logic               out_zero_diagonal,
  // configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import sor_pkg::*;
`include "sor_sparse_sweep_assert.svh"

  localparam int RW = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int JW = RW + 1;
  localparam int NW = (NONZEROS > 1) ? $clog2(NONZEROS) : 1;
  localparam logic signed [63:0] SIGMA_MAX = 64'sh3FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] SIGMA_MIN = -64'sh4000_0000_0000_0000;
  localparam logic signed [48:0] DIFF_MAX = 49'sd35184372088832;
  localparam logic signed [48:0] DIFF_MIN = -49'sd35184372088832;

  typedef enum logic [3:0] {
    S_IDLE, S_CHK, S_ROWD, S_NZA, S_NZD, S_XD, S_ACC, S_DIVGO, S_DIVW, S_MUL, S_UPD
  } state_t;

  state_t state_r;

  // configuration registers
  logic [17:0] relax_r;
  logic [8:0]  rows_r;
  logic        cfg_wr;

  // sweep datapath registers
  logic [JW-1:0]      j_r;
  logic [12:0]        kr_r;
  logic [12:0]        stop_r;
  logic signed [31:0] rhs_r;
  logic signed [31:0] xj_r;
  logic signed [31:0] coef_r;
  logic signed [31:0] ajj_r;
  logic signed [63:0] sigma_r;
  logic signed [63:0] prod_r;
  logic signed [46:0] diff_r;
  logic signed [65:0] prod2_r;
  logic               flag_r;

  // result registers
  logic out_valid_r;
  logic out_done_r;
  logic out_read_r;

  // memory ports
  row_wr_t            row_wr;
  logic [RW-1:0]      row_wr_addr;
  logic signed [31:0] row_wr_x;
  logic [RW-1:0]      row_rd_addr;
  logic [12:0]        row_rd_first;
  logic [12:0]        row_rd_stop;
  logic signed [31:0] row_rd_rhs;
  logic signed [31:0] row_rd_x;
  logic               nz_we;
  logic [NW-1:0]      nz_rd_addr;
  logic signed [31:0] nz_coef;
  logic [7:0]         nz_col;

  // divider
  logic                 div_start;
  logic signed [63:0]   div_num;
  logic                 div_done;
  logic signed [QW-1:0] div_quot;

  // combinational helpers
  logic               accept;
  logic [JW-1:0]      n_rows;
  logic [12:0]        stop_clip;
  logic               row_ok;
  logic               slot_ok;
  logic               col_diag;
  logic               col_ok;
  logic signed [63:0] term;
  logic signed [63:0] sigma_sum;
  logic signed [63:0] sigma_nxt;
  logic signed [48:0] diff_raw;
  logic signed [46:0] diff_nxt;
  logic signed [65:0] delta;
  logic signed [66:0] xn_raw;
  logic signed [31:0] xn;

  assign accept = start && !busy;
  assign busy   = (state_r != S_IDLE);
  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;
  assign prdata = (reg_idx_t'(paddr[2]) == REG_ROWS) ? {23'd0, rows_r} : {14'd0, relax_r};

  always_comb begin
    n_rows    = ({23'd0, rows_r} < ROWS) ? JW'(rows_r) : JW'(ROWS);
    stop_clip = ({19'd0, row_rd_stop} > NONZEROS) ? 13'(NONZEROS) : row_rd_stop;
    row_ok    = ({24'd0, in_row} < ROWS);
    slot_ok   = ({20'd0, in_slot} < NONZEROS);
    col_diag  = (32'(nz_col) == 32'(j_r));
    col_ok    = ({24'd0, nz_col} < ROWS);
    term      = prod_r >>> FRAC_BITS;
    sigma_sum = sigma_r + term;
    if (sigma_sum > SIGMA_MAX) begin
      sigma_nxt = SIGMA_MAX;
    end else if (sigma_sum < SIGMA_MIN) begin
      sigma_nxt = SIGMA_MIN;
    end else begin
      sigma_nxt = sigma_sum;
    end
    diff_raw = 49'(div_quot) - 49'(xj_r);
    if (diff_raw > DIFF_MAX) begin
      diff_nxt = 47'(DIFF_MAX);
    end else if (diff_raw < DIFF_MIN) begin
      diff_nxt = 47'(DIFF_MIN);
    end else begin
      diff_nxt = 47'(diff_raw);
    end
    delta  = prod2_r >>> OMEGA_FRAC;
    xn_raw = 67'(xj_r) + 67'(delta);
    if (xn_raw > 67'sd2147483647) begin
      xn = 32'sh7FFF_FFFF;
    end else if (xn_raw < -67'sd2147483648) begin
      xn = -32'sh8000_0000;
    end else begin
      xn = 32'(xn_raw);
    end
    div_num   = 64'(rhs_r) - sigma_r;
    div_start = (state_r == S_DIVGO) && (ajj_r != 32'sd0);
  end

  // memory address and write selection
  always_comb begin
    row_wr      = '0;
    row_wr_addr = RW'(in_row);
    row_wr_x    = in_guess;
    row_rd_addr = RW'(in_row);
    nz_we       = accept && (func_t'(in_func) == FUNC_LOAD_NZ) && slot_ok;
    nz_rd_addr  = NW'(kr_r);
    if (accept && (func_t'(in_func) == FUNC_LOAD_ROW) && row_ok) begin
      row_wr.info_we = 1'b1;
      row_wr.x_we    = 1'b1;
    end
    case (state_r)
      S_CHK: begin
        row_rd_addr = RW'(j_r);
      end
      S_NZD: begin
        row_rd_addr = RW'(nz_col);
      end
      S_UPD: begin
        row_wr.x_we = 1'b1;
        row_wr_addr = RW'(j_r);
        row_wr_x    = xn;
      end
      default: begin
      end
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      relax_r <= RELAX_RESET;
      rows_r  <= ROWS_USE_RESET;
    end else if (cfg_wr) begin
      case (reg_idx_t'(paddr[2]))
        REG_RELAX: relax_r <= pwdata[17:0];
        REG_ROWS:  rows_r  <= pwdata[8:0];
        default: begin
        end
      endcase
    end
  end

  // request sequencer and sweep walker
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      flag_r      <= 1'b0;
      out_valid_r <= 1'b0;
      out_done_r  <= 1'b0;
      out_read_r  <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      out_done_r  <= 1'b0;
      out_read_r  <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            if (func_t'(in_func) == FUNC_SWEEP) begin
              j_r     <= '0;
              state_r <= S_CHK;
            end else begin
              out_valid_r <= 1'b1;
              out_read_r  <= (func_t'(in_func) == FUNC_READ) && row_ok;
            end
          end
        end
        S_CHK: begin
          if (j_r == n_rows) begin
            out_valid_r <= 1'b1;
            out_done_r  <= 1'b1;
            state_r     <= S_IDLE;
          end else begin
            state_r <= S_ROWD;
          end
        end
        S_ROWD: begin
          kr_r    <= row_rd_first;
          stop_r  <= stop_clip;
          rhs_r   <= row_rd_rhs;
          xj_r    <= row_rd_x;
          sigma_r <= '0;
          ajj_r   <= '0;
          state_r <= S_NZA;
        end
        S_NZA: begin
          state_r <= (kr_r < stop_r) ? S_NZD : S_DIVGO;
        end
        S_NZD: begin
          coef_r <= nz_coef;
          if (col_diag) begin
            ajj_r   <= nz_coef;
            kr_r    <= kr_r + 13'd1;
            state_r <= S_NZA;
          end else if (col_ok) begin
            state_r <= S_XD;
          end else begin
            kr_r    <= kr_r + 13'd1;
            state_r <= S_NZA;
          end
        end
        S_XD: begin
          prod_r  <= 64'(coef_r) * 64'(row_rd_x);
          state_r <= S_ACC;
        end
        S_ACC: begin
          sigma_r <= sigma_nxt;
          kr_r    <= kr_r + 13'd1;
          state_r <= S_NZA;
        end
        S_DIVGO: begin
          if (ajj_r == 32'sd0) begin
            // zero or missing diagonal: keep x, raise sticky flag
            flag_r  <= 1'b1;
            j_r     <= j_r + 1'b1;
            state_r <= S_CHK;
          end else begin
            state_r <= S_DIVW;
          end
        end
        S_DIVW: begin
          if (div_done) begin
            diff_r  <= diff_nxt;
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          prod2_r <= 66'(diff_r) * 66'($signed({1'b0, relax_r}));
          state_r <= S_UPD;
        end
        S_UPD: begin
          j_r     <= j_r + 1'b1;
          state_r <= S_CHK;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid         = out_valid_r;
  assign out_sweep_done    = out_done_r;
  assign out_zero_diagonal = flag_r;
  assign out_value         = out_read_r ? row_rd_x : 32'sd0;

  sor_row_mem #(
    .ROWS(ROWS),
    .RW  (RW)
  ) u_row_mem (
    .clk     (clk),
    .wr_req  (row_wr),
    .wr_addr (row_wr_addr),
    .wr_first(in_row_first),
    .wr_stop (in_row_stop),
    .wr_rhs  (in_rhs),
    .wr_x    (row_wr_x),
    .rd_addr (row_rd_addr),
    .rd_first(row_rd_first),
    .rd_stop (row_rd_stop),
    .rd_rhs  (row_rd_rhs),
    .rd_x    (row_rd_x)
  );

  sor_nz_mem #(
    .NONZEROS(NONZEROS),
    .NW      (NW)
  ) u_nz_mem (
    .clk    (clk),
    .wr_en  (nz_we),
    .wr_addr(NW'(in_slot)),
    .wr_coef(in_coef),
    .wr_col (in_column),
    .rd_addr(nz_rd_addr),
    .rd_coef(nz_coef),
    .rd_col (nz_col)
  );

  sor_div #(
    .FRAC_BITS(FRAC_BITS)
  ) u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .start(div_start),
    .num  (div_num),
    .den  (ajj_r),
    .done (div_done),
    .quot (div_quot)
  );

  // a sweep request always leaves idle on the next cycle
  `SOR_ASSERT_NXT(a_sweep_busy, clk, rst_n, accept && (in_func == FUNC_SWEEP), busy, "sweep not started")
  // sweep completion only on a result strobe
  `SOR_ASSERT_IMP(a_done_valid, clk, rst_n, out_sweep_done, out_valid, "done without strobe")
  // other results come in the cycle after their request
  `SOR_ASSERT_IMP(a_quick_result, clk, rst_n, out_valid && !out_sweep_done, $past(accept), "stray result")
endmodule

// ===== rtl/sor_nz_mem.sv =====
// nonzero store: coefficient and column per slot
module sor_nz_mem #(
  parameter int NONZEROS = sor_pkg::DEF_NONZEROS,
  parameter int NW = 12
) (
  input  logic               clk,
  input  logic               wr_en,
  input  logic [NW-1:0]      wr_addr,
  input  logic signed [31:0] wr_coef,
  input  logic [7:0]         wr_col,
  input  logic [NW-1:0]      rd_addr,
  output logic signed [31:0] rd_coef,
  output logic [7:0]         rd_col
);
  logic [39:0] mem [NONZEROS];
  logic [39:0] rd_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {wr_coef, wr_col};
    end
    rd_r <= mem[rd_addr];
  end

  assign rd_coef = $signed(rd_r[39:8]);
  assign rd_col  = rd_r[7:0];
endmodule

// ===== rtl/sor_row_mem.sv =====
// row store: slot range, rhs and solution per row
module sor_row_mem #(
  parameter int ROWS = sor_pkg::DEF_ROWS,
  parameter int RW = 8
) (
  input  logic               clk,
  input  sor_pkg::row_wr_t   wr_req,
  input  logic [RW-1:0]      wr_addr,
  input  logic [12:0]        wr_first,
  input  logic [12:0]        wr_stop,
  input  logic signed [31:0] wr_rhs,
  input  logic signed [31:0] wr_x,
  input  logic [RW-1:0]      rd_addr,
  output logic [12:0]        rd_first,
  output logic [12:0]        rd_stop,
  output logic signed [31:0] rd_rhs,
  output logic signed [31:0] rd_x
);
  import sor_pkg::*;

  logic [57:0] info_mem [ROWS];
  logic [31:0] x_mem [ROWS];
  logic [57:0] info_r;
  logic [31:0] x_r;

  always_ff @(posedge clk) begin
    if (wr_req.info_we) begin
      info_mem[wr_addr] <= {wr_first, wr_stop, wr_rhs};
    end
    if (wr_req.x_we) begin
      x_mem[wr_addr] <= wr_x;
    end
    info_r <= info_mem[rd_addr];
    x_r    <= x_mem[rd_addr];
  end

  assign rd_first = info_r[57:45];
  assign rd_stop  = info_r[44:32];
  assign rd_rhs   = $signed(info_r[31:0]);
  assign rd_x     = $signed(x_r);
endmodule

// ===== rtl/sor_div.sv =====
// bit-serial fixed point divider with saturating quotient
module sor_div #(
  parameter int FRAC_BITS = sor_pkg::DEF_FRAC_BITS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic signed [63:0]             num,
  input  logic signed [31:0]             den,
  output logic                           done,
  output logic signed [sor_pkg::QW-1:0]  quot
);
  import sor_pkg::*;

  localparam int STEPS = 64 + FRAC_BITS;
  localparam int CW = $clog2(STEPS + 1);
  localparam logic [QW-1:0] QLIM = QW'(1) << 46;

  logic          run_r;
  logic          done_r;
  logic [CW-1:0] cnt_r;
  logic [63:0]   n_r;
  logic [31:0]   dm_r;
  logic [31:0]   r_r;
  logic [QW-1:0] q_r;
  logic          neg_r;
  logic [32:0]   r_sh;
  logic [32:0]   r_sub;
  logic [QW-1:0] q_sh;
  logic          fit;

  always_comb begin
    r_sh  = {r_r, n_r[63]};
    r_sub = r_sh - {1'b0, dm_r};
    fit   = (r_sh >= {1'b0, dm_r});
    q_sh  = {q_r[QW-2:0], fit};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
        n_r   <= num[63] ? 64'(-num) : 64'(num);
        dm_r  <= den[31] ? 32'(-den) : 32'(den);
        r_r   <= '0;
        q_r   <= '0;
        neg_r <= num[63] ^ den[31];
      end else if (run_r) begin
        n_r <= {n_r[62:0], 1'b0};
        r_r <= fit ? r_sub[31:0] : r_sh[31:0];
        if (q_sh > QLIM) begin
          q_r    <= QLIM;
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end else begin
          q_r <= q_sh;
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == CW'(STEPS - 1)) begin
            run_r  <= 1'b0;
            done_r <= 1'b1;
          end
        end
      end
    end
  end

  assign done = done_r;
  assign quot = neg_r ? $signed(-q_r) : $signed(q_r);
endmodule

// ===== dv/sor_sparse_sweep_test.sv =====
// self-checking testbench of the sparse sor sweep engine, directed table then random
module sor_sparse_sweep_test;
  timeunit 1ns;
  timeprecision 1ps;
  import sor_pkg::*;

  localparam int NROW = 256;
  localparam int NSLOT = 4096;

  typedef struct {
    func_t            f;
    logic [7:0]       row;
    logic [11:0]      slot;
    logic [7:0]       column;
    logic [31:0]      coef;
    logic [12:0]      first;
    logic [12:0]      stop;
    logic [31:0]      rhs;
    logic [31:0]      guess;
    bit               typed;   // expected result written in the row itself
    logic [31:0]      ev;
    bit               ed;
    bit               ef;
  } request_t;

  typedef struct {
    logic [31:0] value;
    logic        done;
    logic        flag;
  } outcome_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [1:0] in_func = FUNC_READ;
  logic [7:0] in_row = '0;
  logic [11:0] in_slot = '0;
  logic [7:0] in_column = '0;
  logic signed [31:0] in_coef = '0;
  logic [12:0] in_row_first = '0;
  logic [12:0] in_row_stop = '0;
  logic signed [31:0] in_rhs = '0;
  logic signed [31:0] in_guess = '0;
  logic out_valid;
  logic signed [31:0] out_value;
  logic out_sweep_done;
  logic out_zero_diagonal;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  sor_sparse_sweep u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_func(in_func), .in_row(in_row), .in_slot(in_slot), .in_column(in_column),
    .in_coef(in_coef), .in_row_first(in_row_first), .in_row_stop(in_row_stop),
    .in_rhs(in_rhs), .in_guess(in_guess),
    .out_valid(out_valid), .out_value(out_value), .out_sweep_done(out_sweep_done),
    .out_zero_diagonal(out_zero_diagonal),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // shadow of the engine: configuration, memories and the sticky flag
  logic [17:0] omega_sh;
  logic [8:0]  nrows_sh;
  logic signed [31:0] coef_sh [NSLOT];
  logic [7:0]  col_sh [NSLOT];
  logic [12:0] first_sh [NROW];
  logic [12:0] stop_sh [NROW];
  logic signed [31:0] rhs_sh [NROW];
  logic signed [31:0] x_sh [NROW];
  logic diag_flag_sh;
  bit slot_loaded [NSLOT];   // slots a sweep may touch

  outcome_t pending_results[$];
  request_t typed_rows[$];   // typed expectations waiting for acceptance
  int errors = 0;
  int issued = 0;
  int idle_pct = 0;

  // num * 2^16 / d toward zero, magnitude capped at 2^46
  function automatic longint fixed_quot(input longint num, input logic signed [31:0] d);
    logic [63:0] nm;
    logic [63:0] dm;
    logic [79:0] qq;
    nm = (num < 0) ? 64'(-num) : 64'(num);
    dm = (d < 0) ? 64'(-longint'(d)) : 64'(longint'(d));
    qq = {nm, 16'h0} / {16'h0, dm};
    if (qq > (80'd1 << 46)) qq = 80'd1 << 46;
    return ((num < 0) != (d < 0)) ? -longint'(qq[63:0]) : longint'(qq[63:0]);
  endfunction

  // one in-place relaxation pass over the rows in use
  function automatic void relax_pass();
    int n, stp;
    longint sigma, p, num, q, diff, delta, xn;
    logic signed [31:0] ajj;
    n = (nrows_sh < NROW) ? nrows_sh : NROW;
    for (int j = 0; j < n; j++) begin
      sigma = 0;
      ajj = 0;
      stp = (stop_sh[j] < NSLOT) ? stop_sh[j] : NSLOT;
      for (int k = first_sh[j]; k < stp; k++) begin
        if (col_sh[k] == j) begin
          ajj = coef_sh[k];
        end else begin
          p = (longint'(coef_sh[k]) * longint'(x_sh[col_sh[k]])) >>> 16;
          sigma += p;
          if (sigma > 64'sh3FFF_FFFF_FFFF_FFFF) sigma = 64'sh3FFF_FFFF_FFFF_FFFF;
          if (sigma < -64'sh4000_0000_0000_0000) sigma = -64'sh4000_0000_0000_0000;
        end
      end
      if (ajj == 0) begin
        diag_flag_sh = 1'b1;
        continue;
      end
      num = longint'(rhs_sh[j]) - sigma;
      q = fixed_quot(num, ajj);
      diff = q - longint'(x_sh[j]);
      if (diff > (64'sd1 <<< 45)) diff = 64'sd1 <<< 45;
      if (diff < -(64'sd1 <<< 45)) diff = -(64'sd1 <<< 45);
      delta = (diff * longint'({46'd0, omega_sh})) >>> 16;
      xn = longint'(x_sh[j]) + delta;
      if (xn > 64'sd2147483647) xn = 64'sd2147483647;
      if (xn < -64'sd2147483648) xn = -64'sd2147483648;
      x_sh[j] = xn[31:0];
    end
  endfunction

  // apply one accepted request to the shadow and give its result
  function automatic outcome_t predict_outcome(input logic [1:0] f, input logic [7:0] row,
                                               input logic [11:0] slot);
    outcome_t o;
    o.value = '0;
    o.done = 1'b0;
    case (func_t'(f))
      FUNC_LOAD_NZ: begin
        col_sh[slot] = in_column;
        coef_sh[slot] = in_coef;
      end
      FUNC_LOAD_ROW: begin
        first_sh[row] = in_row_first;
        stop_sh[row] = in_row_stop;
        rhs_sh[row] = in_rhs;
        x_sh[row] = in_guess;
      end
      FUNC_SWEEP: begin
        relax_pass();
        o.done = 1'b1;
      end
      default: o.value = x_sh[row];
    endcase
    o.flag = diag_flag_sh;
    return o;
  endfunction

  // a sweep is only legal when every slot in every swept range was loaded
  function automatic bit sweep_legal();
    int n, stp;
    n = (nrows_sh < NROW) ? nrows_sh : NROW;
    for (int j = 0; j < n; j++) begin
      stp = (stop_sh[j] < NSLOT) ? stop_sh[j] : NSLOT;
      for (int k = first_sh[j]; k < stp; k++)
        if (!slot_loaded[k]) return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // request acceptance: predict at the accepting edge
  always @(posedge clk) begin
    outcome_t o;
    request_t t;
    if (rst_n && start && !busy) begin
      o = predict_outcome(in_func, in_row, in_slot);
      t = typed_rows.pop_front();
      if (t.typed) begin
        o.value = t.ev;
        o.done = t.ed;
        o.flag = t.ef;
      end
      pending_results.push_back(o);
    end
  end

  // result check against the oldest expectation
  always @(posedge clk) begin
    outcome_t e;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        report("unexpected result", out_value, '0);
      end else begin
        e = pending_results.pop_front();
        if (out_value !== e.value) report("value", out_value, e.value);
        if (out_sweep_done !== e.done) report("sweep_done", out_sweep_done, e.done);
        if (out_zero_diagonal !== e.flag) report("zero_diagonal", out_zero_diagonal, e.flag);
      end
    end
  end

  // drive one request and hold it until it is taken
  task automatic send(input request_t r);
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    if (r.f == FUNC_LOAD_NZ) slot_loaded[r.slot] = 1'b1;
    typed_rows.push_back(r);
    start <= 1'b1;
    in_func <= r.f;
    in_row <= r.row;
    in_slot <= r.slot;
    in_column <= r.column;
    in_coef <= r.coef;
    in_row_first <= r.first;
    in_row_stop <= r.stop;
    in_rhs <= r.rhs;
    in_guess <= r.guess;
    do @(posedge clk); while (busy);
    issued++;
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // apb write, only while idle; shadow follows at the access edge
  task automatic write_reg(input reg_idx_t idx, input logic [31:0] val);
    drain();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (idx == REG_RELAX) omega_sh = val[17:0];
    else nrows_sh = val[8:0];
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  function automatic request_t mk(input func_t f, input logic [7:0] row = 0,
                                  input logic [11:0] slot = 0, input logic [7:0] column = 0,
                                  input logic [31:0] coef = 0, input logic [12:0] first = 0,
                                  input logic [12:0] stop = 0, input logic [31:0] rhs = 0,
                                  input logic [31:0] guess = 0);
    request_t r;
    r = '{f, row, slot, column, coef, first, stop, rhs, guess, 1'b0, '0, 1'b0, 1'b0};
    return r;
  endfunction

  function automatic request_t typed(input request_t r, input logic [31:0] ev,
                                     input bit ed, input bit ef);
    r.typed = 1'b1;
    r.ev = ev;
    r.ed = ed;
    r.ef = ef;
    return r;
  endfunction

  // random fixed-point value: full range, extremes or modest magnitudes
  function automatic logic [31:0] rnd_fix();
    case ($urandom_range(4))
      0: return $urandom;
      1: return $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
      default: return 32'($signed($urandom_range(1 << 21)) - (1 << 20));
    endcase
  endfunction

  initial begin
    request_t dir[$];
    request_t r;
    int n, base, cur, cnt, phase;
    omega_sh = RELAX_RESET;
    nrows_sh = ROWS_USE_RESET;
    diag_flag_sh = 1'b0;
    for (int i = 0; i < NSLOT; i++) begin
      coef_sh[i] = '0;
      col_sh[i] = '0;
      slot_loaded[i] = 1'b0;
    end
    for (int i = 0; i < NROW; i++) begin
      first_sh[i] = '0;
      stop_sh[i] = '0;
      rhs_sh[i] = '0;
      x_sh[i] = '0;
    end
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part: a two-row system, then the special cases
    write_reg(REG_ROWS, 32'd2);
    dir.push_back(typed(mk(FUNC_LOAD_NZ, 0, 0, 0, 32'h0002_0000), 0, 0, 0));
    dir.push_back(typed(mk(FUNC_LOAD_NZ, 0, 1, 1, 32'h8000_0000), 0, 0, 0));
    dir.push_back(typed(mk(FUNC_LOAD_NZ, 0, 2, 0, 32'h7fff_ffff), 0, 0, 0));
    dir.push_back(typed(mk(FUNC_LOAD_NZ, 8'hff, 12'hfff, 8'hff, 32'hffff_ffff), 0, 0, 0));
    dir.push_back(typed(mk(FUNC_LOAD_ROW, 0, 0, 0, 0, 0, 1, 32'h0004_0000, 0), 0, 0, 0));
    dir.push_back(typed(mk(FUNC_LOAD_ROW, 1, 0, 0, 0, 1, 3, 32'h7fff_ffff, 32'h8000_0000),
                        0, 0, 0));
    dir.push_back(typed(mk(FUNC_READ, 1), 32'h8000_0000, 0, 0));
    dir.push_back(mk(FUNC_SWEEP));
    dir.push_back(mk(FUNC_READ, 0));
    dir.push_back(mk(FUNC_READ, 1));
    // empty range on row 1: missing diagonal sets the sticky flag
    dir.push_back(mk(FUNC_LOAD_ROW, 1, 0, 0, 0, 3, 3, 32'h0001_0000, 32'h0000_8000));
    dir.push_back(typed(mk(FUNC_SWEEP), 0, 1, 1));
    dir.push_back(typed(mk(FUNC_READ, 1), 32'h0000_8000, 0, 1));
    // top row with a reversed range, all high bits set
    dir.push_back(typed(mk(FUNC_LOAD_ROW, 8'hff, 0, 0, 0, 13'h1fff, 0, 32'h8000_0000,
                           32'h7fff_ffff), 0, 0, 1));
    dir.push_back(typed(mk(FUNC_READ, 8'hff), 32'h7fff_ffff, 0, 1));
    // two diagonals in row 1 (last wins), row 0 range running past the store end
    dir.push_back(mk(FUNC_LOAD_NZ, 0, 5, 1, 32'h0003_0000));
    dir.push_back(mk(FUNC_LOAD_NZ, 0, 6, 1, 32'hfffe_0000));
    dir.push_back(mk(FUNC_LOAD_NZ, 0, 12'hffe, 0, 32'h0001_8000));
    dir.push_back(mk(FUNC_LOAD_ROW, 1, 0, 0, 0, 5, 7, 32'hfff0_0000, 32'h0001_0000));
    dir.push_back(mk(FUNC_LOAD_ROW, 0, 0, 0, 0, 13'd4094, 13'h1fff, 32'h0010_0000,
                     32'h0002_0000));
    dir.push_back(mk(FUNC_SWEEP));
    dir.push_back(mk(FUNC_READ, 0));
    dir.push_back(mk(FUNC_READ, 1));
    foreach (dir[i]) send(dir[i]);
    write_reg(REG_RELAX, 32'd131072);
    send(mk(FUNC_SWEEP));
    send(mk(FUNC_READ, 0));

    // every row loaded with an empty range so the full-size sweeps stay legal
    for (int j = 0; j < NROW; j++)
      send(mk(FUNC_LOAD_ROW, 8'(j), 0, 0, 0, 13'($urandom), 13'd0, rnd_fix(), rnd_fix()));
    write_reg(REG_ROWS, 32'd256);
    send(mk(FUNC_SWEEP));
    write_reg(REG_ROWS, 32'd511);
    write_reg(REG_RELAX, 32'h3ffff);
    send(mk(FUNC_SWEEP));
    write_reg(REG_ROWS, 32'd0);
    send(mk(FUNC_SWEEP));
    send(mk(FUNC_READ, 8'($urandom)));

    // random part: small systems with random content, sweeps, reads and noise
    phase = 0;
    while (issued < 1100) begin
      case (phase % 4)
        0: idle_pct = 0;
        1: idle_pct = 88;
        2: idle_pct = 0;
        default: idle_pct = 6;
      endcase
      phase++;
      case ($urandom_range(5))
        0: write_reg(REG_RELAX, 32'd0);
        1: write_reg(REG_RELAX, 32'd131072);
        2: write_reg(REG_RELAX, 32'd65536);
        default: write_reg(REG_RELAX, $urandom_range(32'h3ffff));
      endcase
      n = $urandom_range(1, 8);
      write_reg(REG_ROWS, n);
      base = ($urandom_range(5) == 0) ? NSLOT - 20 : $urandom_range(NSLOT - 64);
      cur = base;
      for (int j = 0; j < n; j++) begin
        cnt = $urandom_range(0, 5);
        for (int k = 0; k < cnt; k++)
          send(mk(FUNC_LOAD_NZ, 8'($urandom), 12'(cur + k),
                  ($urandom_range(2) != 0 && k == cnt - 1) ? 8'(j) : 8'($urandom),
                  rnd_fix()));
        r = mk(FUNC_LOAD_ROW, 8'(j), 12'($urandom), 8'($urandom), rnd_fix(), 13'(cur),
               13'(cur + cnt), rnd_fix(), rnd_fix());
        // last row near the store end may stop beyond it
        if (j == n - 1 && cur + cnt >= NSLOT - 6)
          r.stop = 13'($urandom_range(NSLOT, 8191));
        send(r);
        cur += cnt;
      end
      for (int s = $urandom_range(3, 10); s > 0; s--) begin
        case ($urandom_range(9))
          0: send(mk(FUNC_LOAD_NZ, 8'($urandom), 12'($urandom), 8'($urandom), rnd_fix()));
          1: send(mk(FUNC_LOAD_ROW, 8'($urandom_range(8, 255)), 0, 0, 0, 13'($urandom),
                     13'($urandom), rnd_fix(), rnd_fix()));
          2, 3, 4: send(mk(FUNC_READ, 8'($urandom), 12'($urandom)));
          default: begin
            if (sweep_legal()) send(mk(FUNC_SWEEP, 8'($urandom), 12'($urandom)));
            else send(mk(FUNC_READ, 8'($urandom_range(n - 1))));
          end
        endcase
      end
      // once, hold off until everything in flight has come back
      if (phase == 7) drain();
    end

    drain();
    repeat (40) @(posedge clk);
    if (errors == 0) begin
      $display("sor_sparse_sweep verification clean");
    end else begin
      $display("sor_sparse_sweep verification failed");
    end
    $finish;
  end

  // run limit well above the slowest legal run
  initial begin
    #80_000_000;
    $display("sor_sparse_sweep verification failed");
    $finish;
  end
endmodule
